[rtl/core/plc_pkg.sv]
// ----------------------------------------------------------------------------
// plc_pkg
// Shared types and constants for the positional list engine.
// ----------------------------------------------------------------------------
package plc_pkg;

  localparam int CAPACITY_DEF = 16;
  // Wide enough for any position or fill at the largest supported capacity
  localparam int OP_POS_W     = 9;
  localparam int ENTRY_W      = 32;
  localparam int POS_W        = 5;
  localparam int COUNT_W      = 5;

  typedef enum logic [2:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_BACK  = 3'd1,
    CMD_INS_AT    = 3'd2,
    CMD_REM_FRONT = 3'd3,
    CMD_REM_BACK  = 3'd4,
    CMD_REM_AT    = 3'd5,
    CMD_RD_FRONT  = 3'd6,
    CMD_RD_AT     = 3'd7
  } cmd_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [POS_W-1:0]   position;
    logic [ENTRY_W-1:0] entry;
  } in_t;

  typedef struct packed {
    logic               ok;
    logic [ENTRY_W-1:0] entry_out;
    logic [COUNT_W-1:0] count;
  } out_t;

  // Broadcast from the controller to every cell of the row
  typedef struct packed {
    logic                ins;
    logic                rem;
    logic [OP_POS_W-1:0] pos;
    logic [ENTRY_W-1:0]  val;
  } cell_op_t;

endpackage

[rtl/core/positional_list_engine_top.sv]
// ----------------------------------------------------------------------------
// positional_list_engine_top
// Ordered list of entry handles with positional insert, remove and read.
// ----------------------------------------------------------------------------
// Every command is accepted while start is high and its result appears on
// out_data with out_strobe in the cycle after acceptance; busy stays low, so
// a command can be issued on every clock. The receiver has no back-pressure
// and must capture each result in its strobe cycle. Entries live in a row of
// CAPACITY cells that shift together in the same cycle, which sets that rate;
// a read selects one cell through an OR tree across the row.
module positional_list_engine_top #(
  parameter int CAPACITY = plc_pkg::CAPACITY_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  plc_pkg::in_t  in_data,
  output logic          out_strobe,
  output plc_pkg::out_t out_data
);
  import plc_pkg::*;

  cell_op_t           op;
  logic [ENTRY_W-1:0] cell_data [CAPACITY];
  logic [ENTRY_W-1:0] cell_rd   [CAPACITY];
  logic [ENTRY_W-1:0] rd_data;

  plc_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .rd_data    (rd_data),
    .op         (op),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ENTRY_W-1:0] left_d;
    logic [ENTRY_W-1:0] right_d;

    if (i == 0) begin : g_first
      assign left_d = op.val;
    end else begin : g_left
      assign left_d = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_d = cell_data[i];
    end else begin : g_right
      assign right_d = cell_data[i+1];
    end

    plc_cell #(
      .IDX (i)
    ) u_cell (
      .clk        (clk),
      .op         (op),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (cell_data[i]),
      .rd_data    (cell_rd[i])
    );
  end

  // at most one cell matches the position, so OR picks it out
  always_comb begin
    rd_data = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      rd_data = rd_data | cell_rd[k];
    end
  end

endmodule

[rtl/core/plc_cell.sv]
// ----------------------------------------------------------------------------
// plc_cell
// One storage slot of the list; shifts with its neighbors on insert/remove.
// ----------------------------------------------------------------------------
module plc_cell #(
  parameter int IDX = 0
) (
  input  logic                          clk,
  input  plc_pkg::cell_op_t             op,
  input  logic [plc_pkg::ENTRY_W-1:0]   left_data,
  input  logic [plc_pkg::ENTRY_W-1:0]   right_data,
  output logic [plc_pkg::ENTRY_W-1:0]   data,
  output logic [plc_pkg::ENTRY_W-1:0]   rd_data
);
  import plc_pkg::*;

  localparam logic [OP_POS_W-1:0] MY_POS = OP_POS_W'(IDX);

  logic [ENTRY_W-1:0] data_r;
  logic [ENTRY_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (op.ins) begin
      if (MY_POS > op.pos) begin
        data_nxt = left_data;
      end else if (MY_POS == op.pos) begin
        data_nxt = op.val;
      end
    end else if (op.rem) begin
      if (MY_POS >= op.pos) begin
        data_nxt = right_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data    = data_r;
  assign rd_data = (MY_POS == op.pos) ? data_r : '0;

endmodule

[rtl/core/plc_ctrl.sv]
// ----------------------------------------------------------------------------
// plc_ctrl
// Command decode, fill count and result register for the cell row.
// ----------------------------------------------------------------------------
module plc_ctrl #(
  parameter int CAPACITY = plc_pkg::CAPACITY_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  plc_pkg::in_t                in_data,
  input  logic [plc_pkg::ENTRY_W-1:0] rd_data,
  output plc_pkg::cell_op_t           op,
  output logic                        out_strobe,
  output plc_pkg::out_t               out_data
);
  import plc_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [OP_POS_W-1:0] CAP_POS = OP_POS_W'(CAPACITY);

  logic [CNT_W-1:0]    fill_r;
  logic [CNT_W-1:0]    fill_nxt;
  logic [OP_POS_W-1:0] fill_w;
  logic [OP_POS_W-1:0] tgt;
  logic                is_ins;
  logic                is_rem;
  logic                ok;
  logic                accept;
  logic                out_strobe_r;
  out_t                out_data_r;

  assign busy   = 1'b0;
  assign accept = start & ~busy;
  assign fill_w = OP_POS_W'(fill_r);

  always_comb begin
    tgt    = '0;
    is_ins = 1'b0;
    is_rem = 1'b0;
    unique case (in_data.cmd)
      CMD_INS_FRONT: begin tgt = '0; is_ins = 1'b1; end
      CMD_INS_BACK:  begin tgt = fill_w; is_ins = 1'b1; end
      CMD_INS_AT:    begin tgt = OP_POS_W'(in_data.position); is_ins = 1'b1; end
      CMD_REM_FRONT: begin tgt = '0; is_rem = 1'b1; end
      // wraps on an empty list, which then fails the bound check
      CMD_REM_BACK:  begin tgt = fill_w - OP_POS_W'(1); is_rem = 1'b1; end
      CMD_REM_AT:    begin tgt = OP_POS_W'(in_data.position); is_rem = 1'b1; end
      CMD_RD_FRONT:  tgt = '0;
      CMD_RD_AT:     tgt = OP_POS_W'(in_data.position);
      default:       tgt = '0;
    endcase
  end

  assign ok = is_ins ? ((fill_w < CAP_POS) && (tgt <= fill_w)) : (tgt < fill_w);

  assign op.ins = accept & is_ins & ok;
  assign op.rem = accept & is_rem & ok;
  assign op.pos = tgt;
  assign op.val = in_data.entry;

  always_comb begin
    fill_nxt = fill_r;
    if (op.ins) begin
      fill_nxt = fill_r + CNT_W'(1);
    end else if (op.rem) begin
      fill_nxt = fill_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r       <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      fill_r       <= fill_nxt;
      out_strobe_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r.ok        <= ok;
      out_data_r.entry_out <= (ok && !is_ins && !is_rem) ? rd_data : '0;
      out_data_r.count     <= COUNT_W'(fill_nxt);
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

endmodule
